FILE: src/msc_pkg.sv
// Shared types and constants for the mapped string compare unit.
package msc_pkg;

  localparam int CHAR_W = 8;
  localparam int DIFF_W = 9;
  localparam int LIMIT_FIELD_W = 16;
  localparam int OP_W = 2;

  localparam logic [CHAR_W-1:0] TERMINATOR = 8'd0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPARE = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic                     start_of_string;
    logic [CHAR_W-1:0]        char_a;
    logic [CHAR_W-1:0]        char_b;
    logic                     bounded;
    logic [LIMIT_FIELD_W-1:0] length_limit;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] mapped_a;
    logic [CHAR_W-1:0] mapped_b;
  } lookup_t;

endpackage

FILE: src/msc_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface msc_in_if;
  import msc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic                     start_of_string;
  logic [CHAR_W-1:0]        char_a;
  logic [CHAR_W-1:0]        char_b;
  logic [CHAR_W-1:0]        map_value;
  logic                     bounded;
  logic [LIMIT_FIELD_W-1:0] length_limit;

  modport source (output valid, operation, start_of_string, char_a, char_b, map_value,
                  bounded, length_limit, input ready);
  modport sink (input valid, operation, start_of_string, char_a, char_b, map_value,
                bounded, length_limit, output ready);
endinterface

interface msc_out_if;
  import msc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] difference;
  logic                     okay;

  modport source (output valid, difference, okay, input ready);
  modport sink (input valid, difference, okay, output ready);
endinterface

FILE: src/mapped_string_compare_unit.sv
// Top level of the mapped string compare unit.
// Takes one item per cycle unless input ready drops. An accepted item enters the lookup
// stage and both map entries are read from the character map at that edge (map writes
// land at the same edge). When the item leaves the lookup stage, its mapped values fold
// into the string state and, if it decides, the result register loads at that edge. Input
// ready drops only while a result waits untaken and an item sits in the lookup stage. The
// map reads as zero after reset through per-entry valid bits, so no clearing pass is needed.
module mapped_string_compare_unit #(
  parameter int MAP_ENTRIES = 256,
  parameter int LIMIT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  msc_in_if.sink    in_item,
  msc_out_if.source result
);
  import msc_pkg::*;

  logic             accept;
  logic             advance;
  logic             stage_valid;
  item_t            stage_item;
  lookup_t          lookup;

  assign in_item.ready = !stage_valid || advance;
  assign accept        = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.operation       <= in_item.operation;
      stage_item.start_of_string <= in_item.start_of_string;
      stage_item.char_a          <= in_item.char_a;
      stage_item.char_b          <= in_item.char_b;
      stage_item.bounded         <= in_item.bounded;
      stage_item.length_limit    <= in_item.length_limit;
    end
  end

  msc_map_mem #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_map_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .wr_en   (accept && (in_item.operation == OP_WRITE)),
    .char_a  (in_item.char_a),
    .char_b  (in_item.char_b),
    .wr_value(in_item.map_value),
    .lookup  (lookup)
  );

  msc_decide #(
    .LIMIT_BITS(LIMIT_BITS)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .item_valid(stage_valid),
    .item      (stage_item),
    .lookup    (lookup),
    .advance   (advance),
    .result    (result)
  );

endmodule

FILE: src/msc_map_mem.sv
// Character map memory with one write port, two registered read ports and per-entry valid bits.
module msc_map_mem #(
  parameter int MAP_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic                    wr_en,
  input  logic [msc_pkg::CHAR_W-1:0] char_a,
  input  logic [msc_pkg::CHAR_W-1:0] char_b,
  input  logic [msc_pkg::CHAR_W-1:0] wr_value,
  output msc_pkg::lookup_t        lookup
);
  import msc_pkg::*;

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  logic [CHAR_W-1:0]      mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] entry_valid;
  logic [CHAR_W-1:0]      raw_a;
  logic [CHAR_W-1:0]      raw_b;
  logic                   hit_a;
  logic                   hit_b;
  logic                   in_range_a;
  logic                   in_range_b;
  logic [IDX_W-1:0]       idx_a;
  logic [IDX_W-1:0]       idx_b;

  assign idx_a = char_a[IDX_W-1:0];
  assign idx_b = char_b[IDX_W-1:0];
  assign in_range_a = {1'b0, char_a} < (CHAR_W+1)'(MAP_ENTRIES);
  assign in_range_b = {1'b0, char_b} < (CHAR_W+1)'(MAP_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_en && in_range_a) begin
      mem[idx_a] <= wr_value;
    end
    if (rd_en) begin
      raw_a <= mem[idx_a];
      raw_b <= mem[idx_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      hit_a       <= 1'b0;
      hit_b       <= 1'b0;
    end else begin
      if (wr_en && in_range_a) begin
        entry_valid[idx_a] <= 1'b1;
      end
      if (rd_en) begin
        hit_a <= in_range_a && entry_valid[idx_a];
        hit_b <= in_range_b && entry_valid[idx_b];
      end
    end
  end

  assign lookup.mapped_a = hit_a ? raw_a : '0;
  assign lookup.mapped_b = hit_b ? raw_b : '0;

endmodule

FILE: src/msc_decide.sv
// String state, decision logic and result register.
module msc_decide #(
  parameter int LIMIT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  msc_pkg::item_t    item,
  input  msc_pkg::lookup_t  lookup,
  output logic              advance,
  msc_out_if.source         result
);
  import msc_pkg::*;

  logic [LIMIT_BITS-1:0]               remaining_count;
  logic [LIMIT_BITS-1:0]               remaining_count_next;
  logic                                limit_active;
  logic                                limit_active_next;
  logic                                decided;
  logic                                decided_next;
  logic                                emit;
  logic signed [DIFF_W-1:0]            diff_value;
  logic                                okay_value;
  logic [LIMIT_BITS+LIMIT_FIELD_W-1:0] limit_ext;
  logic [LIMIT_BITS-1:0]               limit_cut;
  logic [LIMIT_BITS-1:0]               count_eff;
  logic                                active_eff;
  logic                                live;

  assign limit_ext  = {{LIMIT_BITS{1'b0}}, item.length_limit};
  assign limit_cut  = limit_ext[LIMIT_BITS-1:0];
  assign count_eff  = item.start_of_string ? limit_cut : remaining_count;
  assign active_eff = item.start_of_string ? item.bounded : limit_active;
  assign live       = item.start_of_string || !decided;

  assign advance = item_valid && (!result.valid || result.ready);

  always_comb begin
    emit                 = 1'b0;
    diff_value           = '0;
    okay_value           = 1'b0;
    decided_next         = decided;
    limit_active_next    = limit_active;
    remaining_count_next = remaining_count;
    case (op_t'(item.operation))
      OP_COMPARE: begin
        if (live) begin
          limit_active_next    = active_eff;
          remaining_count_next = count_eff;
          if (item.start_of_string && item.bounded && limit_cut == '0) begin
            emit = 1'b1;
          end else if (lookup.mapped_a != lookup.mapped_b) begin
            emit       = 1'b1;
            diff_value = DIFF_W'({1'b0, item.char_a}) - DIFF_W'({1'b0, item.char_b});
          end else if (item.char_a == TERMINATOR) begin
            emit = 1'b1;
          end else if (active_eff) begin
            remaining_count_next = count_eff - LIMIT_BITS'(1);
            emit                 = (remaining_count_next == '0);
          end
          decided_next = emit;
        end
      end
      OP_CHECK: begin
        if (live) begin
          if (item.char_a == TERMINATOR) begin
            emit       = 1'b1;
            okay_value = 1'b1;
          end else if (lookup.mapped_a == '0) begin
            emit = 1'b1;
          end
          decided_next = emit;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_count <= '0;
      limit_active    <= 1'b0;
      decided         <= 1'b1;
      result.valid    <= 1'b0;
    end else begin
      if (advance) begin
        remaining_count <= remaining_count_next;
        limit_active    <= limit_active_next;
        decided         <= decided_next;
      end
      if (advance && emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.difference <= diff_value;
      result.okay       <= okay_value;
    end
  end

endmodule

FILE: bench/mapped_string_compare_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mapped string compare unit with a scoreboard class.
module mapped_string_compare_unit_test;
  import msc_pkg::*;

  localparam int MAP_ENTRIES = 256;
  localparam int LIMIT_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]          operation;
    logic                     start_of_string;
    logic [CHAR_W-1:0]        char_a;
    logic [CHAR_W-1:0]        char_b;
    logic [CHAR_W-1:0]        map_value;
    logic                     bounded;
    logic [LIMIT_FIELD_W-1:0] length_limit;
  } stim_t;

  typedef struct {
    logic signed [DIFF_W-1:0] difference;
    logic                     okay;
  } outcome_t;

  class compare_scoreboard;
    logic [CHAR_W-1:0] char_map [MAP_ENTRIES];
    logic [LIMIT_BITS-1:0] remaining;
    bit limit_on;
    bit decided;
    outcome_t pending_q[$];
    int unsigned errors;
    int unsigned items_noted;
    int unsigned compare_results;
    int unsigned check_results;
    int unsigned limit_results;

    function new();
      foreach (char_map[i]) char_map[i] = '0;
      remaining = '0;
      limit_on = 0;
      decided = 1;
    endfunction

    function logic [CHAR_W-1:0] lookup(logic [CHAR_W-1:0] idx);
      if (int'(idx) < MAP_ENTRIES) return char_map[idx];
      return '0;
    endfunction

    function void note_input(stim_t s);
      outcome_t r;
      bit fire;
      bit live;
      logic [CHAR_W-1:0] ma;
      logic [CHAR_W-1:0] mb;
      fire = 0;
      r.difference = '0;
      r.okay = 0;
      ma = lookup(s.char_a);
      mb = lookup(s.char_b);
      live = s.start_of_string || !decided;
      items_noted++;
      case (s.operation)
        OP_WRITE: begin
          if (int'(s.char_a) < MAP_ENTRIES) char_map[s.char_a] = s.map_value;
        end
        OP_COMPARE: begin
          if (s.start_of_string) begin
            decided = 0;
            limit_on = s.bounded;
            remaining = s.length_limit[LIMIT_BITS-1:0];
          end
          if (live) begin
            if (s.start_of_string && s.bounded && remaining == '0) begin
              fire = 1;
              limit_results++;
            end else if (ma != mb) begin
              fire = 1;
              r.difference = {1'b0, s.char_a} - {1'b0, s.char_b};
            end else if (s.char_a == TERMINATOR) begin
              fire = 1;
            end else if (limit_on) begin
              remaining = remaining - 1'b1;
              if (remaining == '0) begin
                fire = 1;
                limit_results++;
              end
            end
            if (fire) compare_results++;
          end
        end
        OP_CHECK: begin
          if (s.start_of_string) decided = 0;
          if (live) begin
            if (s.char_a == TERMINATOR) begin
              fire = 1;
              r.okay = 1;
            end else if (ma == '0) begin
              fire = 1;
            end
            if (fire) check_results++;
          end
        end
        default: begin
        end
      endcase
      if (fire) begin
        decided = 1;
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(logic signed [DIFF_W-1:0] difference, logic okay);
      outcome_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, difference %0d okay %0d", $time, difference, okay);
        return;
      end
      exp_r = pending_q.pop_front();
      if (difference !== exp_r.difference) begin
        errors++;
        $display("%0t: difference expected %0d, actual %0d", $time, exp_r.difference,
                 difference);
      end
      if (okay !== exp_r.okay) begin
        errors++;
        $display("%0t: okay expected %0d, actual %0d", $time, exp_r.okay, okay);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  compare_scoreboard sb = new();

  msc_in_if in_ch();
  msc_out_if out_ch();

  mapped_string_compare_unit #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .LIMIT_BITS (LIMIT_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_item(in_ch),
    .result (out_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, sb.pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.difference, out_ch.okay);
  end

  function automatic stim_t mk(logic [OP_W-1:0] op, logic sos, logic [7:0] a, logic [7:0] b,
                               logic [7:0] val, logic bnd, logic [15:0] lim);
    stim_t s;
    s.operation = op;
    s.start_of_string = sos;
    s.char_a = a;
    s.char_b = b;
    s.map_value = val;
    s.bounded = bnd;
    s.length_limit = lim;
    return s;
  endfunction

  task automatic send_item(input stim_t s);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.operation = s.operation;
    in_ch.start_of_string = s.start_of_string;
    in_ch.char_a = s.char_a;
    in_ch.char_b = s.char_b;
    in_ch.map_value = s.map_value;
    in_ch.bounded = s.bounded;
    in_ch.length_limit = s.length_limit;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(s);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return 8'($urandom_range(8'h20, 8'h7e));
    if (roll < 85) return TERMINATOR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] partner_of(logic [7:0] a);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return a;
    if (roll < 80) begin
      if ((a >= 8'h41 && a <= 8'h5a) || (a >= 8'h61 && a <= 8'h7a)) return a ^ 8'h20;
      return a;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_compare_string();
    int unsigned len;
    logic bnd;
    logic [15:0] lim;
    int unsigned roll;
    logic [7:0] a;
    len = $urandom_range(1, 10);
    bnd = ($urandom_range(99) < 60);
    roll = $urandom_range(99);
    if (roll < 70) lim = 16'($urandom_range(0, 6));
    else if (roll < 90) lim = 16'($urandom_range(7, 20));
    else lim = 16'($urandom_range(16'hffff));
    for (int i = 0; i < len; i++) begin
      a = pick_char();
      send_item(mk(OP_COMPARE, i == 0, a, partner_of(a), 8'($urandom_range(255)),
                   i == 0 ? bnd : 1'($urandom_range(1)),
                   i == 0 ? lim : 16'($urandom_range(16'hffff))));
    end
    if ($urandom_range(99) < 80)
      send_item(mk(OP_COMPARE, 0, TERMINATOR, TERMINATOR, 8'd0, 0, 16'd0));
    else
      send_item(mk(OP_COMPARE, 0, TERMINATOR, 8'($urandom_range(255)), 8'd0, 0, 16'd0));
  endtask

  task automatic send_check_string();
    int unsigned len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      send_item(mk(OP_CHECK, i == 0, pick_char(), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 1'($urandom_range(1)),
                   16'($urandom_range(16'hffff))));
    send_item(mk(OP_CHECK, 0, TERMINATOR, 8'd0, 8'd0, 0, 16'd0));
  endtask

  task automatic send_noise();
    send_item(mk(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                 16'($urandom_range(16'hffff))));
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start_count;
    int unsigned roll;
    start_count = sb.items_noted;
    while (sb.items_noted - start_count < target) begin
      roll = $urandom_range(99);
      if (roll < 40) send_compare_string();
      else if (roll < 75) send_check_string();
      else if (roll < 90)
        send_item(mk(OP_WRITE, 1'($urandom_range(1)), 8'($urandom_range(255)), 8'd0,
                     $urandom_range(99) < 20 ? 8'd0 : 8'($urandom_range(1, 255)), 0, 16'd0));
      else send_noise();
    end
  endtask

  initial begin
    logic [7:0] folded;
    rst = 1;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    in_ch.valid = 0;
    in_ch.operation = OP_WRITE;
    in_ch.start_of_string = 0;
    in_ch.char_a = '0;
    in_ch.char_b = '0;
    in_ch.map_value = '0;
    in_ch.bounded = 0;
    in_ch.length_limit = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_item(mk(OP_CHECK, 1, 8'hff, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_WRITE, 0, 8'h41, 8'hff, 8'h61, 1, 16'hffff));
    send_item(mk(OP_WRITE, 1, 8'h61, 8'h00, 8'h61, 0, 16'h0000));
    send_item(mk(OP_WRITE, 0, 8'hff, 8'h00, 8'hff, 0, 16'h0000));
    send_item(mk(OP_WRITE, 0, 8'h00, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_WRITE, 0, 8'h80, 8'h00, 8'h01, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h41, 8'h61, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 0, 8'hff, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h00, 8'hff, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 0, 8'h41, 8'h42, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h41, 8'h42, 8'h00, 1, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h41, 8'h61, 8'h00, 1, 16'h0002));
    send_item(mk(OP_COMPARE, 0, 8'h61, 8'h41, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h00, 8'h00, 8'h00, 1, 16'hffff));
    send_item(mk(OP_COMPARE, 1, 8'h10, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 0, 8'h00, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_CHECK, 1, 8'h41, 8'h00, 8'h00, 1, 16'h0000));
    send_item(mk(OP_CHECK, 0, 8'h00, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_UNUSED, 1, 8'h41, 8'h41, 8'hff, 1, 16'h0000));
    send_item(mk(OP_COMPARE, 1, 8'h41, 8'h41, 8'h00, 0, 16'h0000));
    send_item(mk(OP_CHECK, 0, 8'h05, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_CHECK, 1, 8'h80, 8'h00, 8'h00, 0, 16'h0000));
    send_item(mk(OP_COMPARE, 0, 8'h80, 8'h80, 8'h00, 0, 16'h0000));
    send_item(mk(OP_CHECK, 0, 8'h7f, 8'h00, 8'h00, 0, 16'h0000));

    for (int c = 8'h20; c <= 8'h7e; c++) begin
      folded = (c >= 8'h41 && c <= 8'h5a) ? 8'(c) | 8'h20 : 8'(c);
      if (c % 7 == 3) folded = 8'h00;
      send_item(mk(OP_WRITE, 0, 8'(c), 8'd0, folded, 0, 16'd0));
    end

    hold_left = 400;
    for (int i = 0; i < 30; i++) send_item(mk(OP_CHECK, 1, TERMINATOR, 8'd0, 8'd0, 0, 16'd0));

    idle_pct = 0;
    stall_pct = 0;
    run_phase(420);
    idle_pct = 45;
    stall_pct = 0;
    run_phase(420);
    idle_pct = 0;
    stall_pct = 45;
    run_phase(420);
    idle_pct = 23;
    stall_pct = 23;
    run_phase(420);

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d input transfers: %0d compare and %0d check decisions,",
             sb.items_noted, sb.compare_results, sb.check_results);
    $display("%0d of them at a length limit, under four idle and stall mixes.",
             sb.limit_results);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
